>>> src/ptp_pkg.sv
`default_nettype none

package ptp_pkg;

    // Width of every time value (unsigned Q16.16 seconds).
    localparam int TIME_BITS  = 32;
    localparam int DELTA_BITS = 24;
    localparam int CFG_BITS   = 32;
    localparam int CNT_W      = $clog2(TIME_BITS);

    localparam logic [TIME_BITS-1:0] TIME_ZERO = '0;
    localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
    localparam logic [TIME_BITS-1:0] TIME_ONE  = TIME_BITS'(65536);

    typedef enum logic [2:0] {
        CMD_PLAY  = 3'd0,
        CMD_PAUSE = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEEK  = 3'd3,
        CMD_TICK  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PAUSED  = 2'd1,
        MODE_PLAYING = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_LOOP_ENABLE    = 2'd0,
        REG_LOOP_START     = 2'd1,
        REG_LOOP_END       = 2'd2,
        REG_TRACK_DURATION = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WRAP,
        ST_MOD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]            command;
        logic [TIME_BITS-1:0]  seek_position;
        logic [DELTA_BITS-1:0] tick_delta;
    } t_in_item;

    typedef struct packed {
        logic [TIME_BITS-1:0] position_now;
        logic [1:0]           transport_mode;
        logic                 at_loop_end;
        logic                 end_reached;
        logic                 saturated;
    } t_out_item;

    typedef struct packed {
        logic                 loop_enable;
        logic [TIME_BITS-1:0] loop_start;
        logic [TIME_BITS-1:0] loop_end;
        logic [TIME_BITS-1:0] track_duration;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] dividend;
        logic [TIME_BITS-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic                 done;
        logic [TIME_BITS-1:0] rem;
    } t_mod_sts;

endpackage

`default_nettype wire

>>> src/ptp_cfg.sv
`default_nettype none

module ptp_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [ptp_pkg::CFG_BITS-1:0]  i_cfg_data,
    output ptp_pkg::t_cfg                      o_cfg
);

    ptp_pkg::t_cfg r_cfg;
    ptp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                ptp_pkg::REG_LOOP_ENABLE:    n_cfg.loop_enable    = i_cfg_data[0];
                ptp_pkg::REG_LOOP_START:     n_cfg.loop_start     =
                    ptp_pkg::TIME_BITS'(i_cfg_data);
                ptp_pkg::REG_LOOP_END:       n_cfg.loop_end       =
                    ptp_pkg::TIME_BITS'(i_cfg_data);
                ptp_pkg::REG_TRACK_DURATION: n_cfg.track_duration =
                    ptp_pkg::TIME_BITS'(i_cfg_data);
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_enable    <= 1'b0;
            r_cfg.loop_start     <= ptp_pkg::TIME_ZERO;
            r_cfg.loop_end       <= ptp_pkg::TIME_ONE;
            r_cfg.track_duration <= ptp_pkg::TIME_ZERO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/ptp_mod.sv
`default_nettype none

// Restoring remainder: the dividend shifts out one bit per cycle, MSB first,
// into a remainder register that is conditionally reduced by the divisor.
module ptp_mod (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire ptp_pkg::t_mod_req i_req,
    output ptp_pkg::t_mod_sts o_sts
);

    localparam int TB = ptp_pkg::TIME_BITS;

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [ptp_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [TB-1:0]                r_dvd, n_dvd;
    logic [TB-1:0]                r_div, n_div;
    logic [TB-1:0]                r_rem, n_rem;
    logic [TB:0]                  trial;
    logic [TB:0]                  diff;

    always_comb begin
        trial  = {r_rem, r_dvd[TB-1]};
        diff   = trial - {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = ptp_pkg::CNT_W'(TB - 1);
            n_dvd  = i_req.dividend;
            n_div  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[TB-2:0], 1'b0};
            n_rem = diff[TB] ? trial[TB-1:0] : diff[TB-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_sts.done = r_done;
    assign o_sts.rem  = r_rem;

endmodule

`default_nettype wire

>>> src/playback_transport_position_top.sv
// Playback transport: keeps a playing flag and a position in unsigned Q16.16
// seconds and executes one command per transaction (play, pause, stop, seek,
// tick), returning one result transaction with the new position, the
// transport mode and the end, loop and saturation flags. Items are handled one
// at a time. Play, pause, stop, seek, an unused command code and a tick while
// not playing go from the idle state through the execute and done states to
// the result; a tick while playing also passes the wrap state, and a tick
// that wraps inside the loop range then waits in the remainder state for the
// bit-serial remainder unit, which reduces the overshoot past the loop end by
// the loop length one dividend bit per cycle. The result sits in an output
// register, so the next transaction is taken while an earlier result waits
// for the consumer. Configuration is written through a plain write port with
// no handshake and must only change while the block is idle.
`default_nettype none

module playback_transport_position_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Command channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire ptp_pkg::t_in_item            i_in_data,
    // Result channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output ptp_pkg::t_out_item                o_out_data,
    // Configuration write port.
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_idx,
    input  wire logic [ptp_pkg::CFG_BITS-1:0] i_cfg_data
);

    localparam int TB = ptp_pkg::TIME_BITS;

    ptp_pkg::t_cfg     cfg;
    ptp_pkg::t_mod_req mod_req;
    ptp_pkg::t_mod_sts mod_sts;

    ptp_pkg::t_state   r_state, n_state;

    // Transport state.
    logic              r_playing, n_playing;
    logic [TB-1:0]     r_pos, n_pos;

    // Captured command.
    logic [2:0]                     r_cmd, n_cmd;
    logic [TB-1:0]                  r_seek, n_seek;
    logic [ptp_pkg::DELTA_BITS-1:0] r_delta, n_delta;

    // Tick work registers.
    logic [TB-1:0]     r_sum, n_sum;
    logic              r_sat, n_sat;
    logic              r_end, n_end;

    // Output register.
    logic                r_out_valid, n_out_valid;
    ptp_pkg::t_out_item  r_out, n_out;

    logic [TB:0]       sum_wide;
    logic [TB:0]       delta_ext;
    logic              pos_at_end;
    logic [1:0]        mode_now;

    ptp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ptp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_sts   (mod_sts)
    );

    // The tick sum carries one extra bit so that overflow can be caught and
    // saturated to the largest time value.
    assign delta_ext = (TB + 1)'(r_delta);
    assign sum_wide  = {1'b0, r_pos} + delta_ext;

    // Status derived from the committed state, used when the result is loaded.
    assign pos_at_end = cfg.loop_enable && (r_pos >= cfg.loop_end);
    always_comb begin
        if (r_playing) begin
            mode_now = ptp_pkg::MODE_PLAYING;
        end else if (r_pos != ptp_pkg::TIME_ZERO) begin
            mode_now = ptp_pkg::MODE_PAUSED;
        end else begin
            mode_now = ptp_pkg::MODE_STOPPED;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_playing   = r_playing;
        n_pos       = r_pos;
        n_cmd       = r_cmd;
        n_seek      = r_seek;
        n_delta     = r_delta;
        n_sum       = r_sum;
        n_sat       = r_sat;
        n_end       = r_end;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = r_sum - cfg.loop_end;
        mod_req.divisor  = cfg.loop_end - cfg.loop_start;

        case (r_state)
            ptp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_seek  = i_in_data.seek_position;
                    n_delta = i_in_data.tick_delta;
                    n_state = ptp_pkg::ST_EXEC;
                end
            end

            ptp_pkg::ST_EXEC: begin
                n_sat   = 1'b0;
                n_end   = 1'b0;
                n_state = ptp_pkg::ST_DONE;
                case (r_cmd)
                    ptp_pkg::CMD_PLAY:  n_playing = 1'b1;
                    ptp_pkg::CMD_PAUSE: n_playing = 1'b0;
                    ptp_pkg::CMD_STOP: begin
                        n_playing = 1'b0;
                        n_pos     = ptp_pkg::TIME_ZERO;
                    end
                    ptp_pkg::CMD_SEEK: begin
                        // A zero duration means the length is unknown, so the
                        // target is taken as it is.
                        if (cfg.track_duration != ptp_pkg::TIME_ZERO &&
                            r_seek > cfg.track_duration) begin
                            n_pos = cfg.track_duration;
                        end else begin
                            n_pos = r_seek;
                        end
                    end
                    ptp_pkg::CMD_TICK: begin
                        if (r_playing) begin
                            n_sat   = sum_wide[TB];
                            n_sum   = sum_wide[TB] ? ptp_pkg::TIME_MAX : sum_wide[TB-1:0];
                            n_state = ptp_pkg::ST_WRAP;
                        end
                    end
                    default: n_state = ptp_pkg::ST_DONE;
                endcase
            end

            ptp_pkg::ST_WRAP: begin
                n_state = ptp_pkg::ST_DONE;
                if (cfg.loop_enable) begin
                    // Wrap only for a proper loop range; otherwise the sum
                    // stands and no duration clamp applies.
                    if (r_sum >= cfg.loop_end && cfg.loop_end > cfg.loop_start) begin
                        mod_req.start = 1'b1;
                        n_state       = ptp_pkg::ST_MOD;
                    end else begin
                        n_pos = r_sum;
                    end
                end else if (r_sum >= cfg.track_duration) begin
                    n_pos     = cfg.track_duration;
                    n_playing = 1'b0;
                    n_end     = 1'b1;
                end else begin
                    n_pos = r_sum;
                end
            end

            ptp_pkg::ST_MOD: begin
                if (mod_sts.done) begin
                    // The remainder is below the loop length, so the sum
                    // stays below the loop end and cannot overflow.
                    n_pos   = cfg.loop_start + mod_sts.rem;
                    n_state = ptp_pkg::ST_DONE;
                end
            end

            ptp_pkg::ST_DONE: begin
                // Hand the result over as soon as the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out.position_now   = r_pos;
                    n_out.transport_mode = mode_now;
                    n_out.at_loop_end    = pos_at_end;
                    n_out.end_reached    = r_end;
                    n_out.saturated      = r_sat;
                    n_out_valid          = 1'b1;
                    n_state              = ptp_pkg::ST_IDLE;
                end
            end

            default: n_state = ptp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing   <= 1'b0;
            r_pos       <= ptp_pkg::TIME_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_playing   <= n_playing;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_seek  <= n_seek;
        r_delta <= n_delta;
        r_sum   <= n_sum;
        r_sat   <= n_sat;
        r_end   <= n_end;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> src/ptp_checker.sv
`default_nettype none

module ptp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire ptp_pkg::t_out_item           o_out_data
);

    // A pending result is not dropped before the consumer takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // One command is in work at a time: input closes right after a transaction.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a command is in work");

    // Reaching the end of the material always stops playback.
    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_reached |->
        o_out_data.transport_mode != ptp_pkg::MODE_PLAYING)
        else $error("end reached while still playing");

    // Stopped mode is only reported with the position at zero.
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.transport_mode == ptp_pkg::MODE_STOPPED |->
        o_out_data.position_now == ptp_pkg::TIME_ZERO)
        else $error("stopped with nonzero position");

endmodule

bind playback_transport_position_top ptp_checker u_ptp_checker (.*);

`default_nettype wire

>>> tb/tb_playback_transport_position_top.sv
`default_nettype none

// Self-checking bench for the playback transport. Commands go in over a
// valid/ready channel, results come back over another, and every result
// transaction is compared against a typed-in value or a behavioral copy of
// the transport kept in this module. A short table of hand-picked commands
// runs first, then random phases, each under its own loop and duration setting.
module tb_playback_transport_position_top;
    import ptp_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    // Quiet time after the last result is back, before register writes and
    // at the end of the run.
    localparam int SETTLE_CYCLES   = 45;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int HOLD_AT_ITEM    = 700;
    localparam int IDLE_PCT        = 18;
    localparam int PHASE_ITEMS     = 185;

    // Command codes the block does not define. It must report status for
    // these and leave its state alone.
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        ROW_CMD,        // result checked against the transport copy
        ROW_CMD_TYPED,  // result typed into the table by hand
        ROW_REG         // register write, issued only once the block is quiet
    } t_row_kind;

    typedef struct {
        t_row_kind           kind;
        t_in_item            item;
        t_out_item           want;
        t_cfg_idx            idx;
        logic [CFG_BITS-1:0] value;
    } t_row;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    t_in_item            in_data;
    logic                out_valid;
    logic                out_ready;
    t_out_item           out_data;
    logic                cfg_we;
    t_cfg_idx            cfg_idx;
    logic [CFG_BITS-1:0] cfg_data;

    playback_transport_position_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // These variables hold the transport copy: its state and its view of
    // the registers.
    bit                   trk_playing;
    logic [TIME_BITS-1:0] trk_position;
    bit                   cfg_loop_on;
    logic [TIME_BITS-1:0] cfg_loop_start;
    logic [TIME_BITS-1:0] cfg_loop_end;
    logic [TIME_BITS-1:0] cfg_duration;

    // The queue holds expected results in the order their commands were
    // accepted.
    t_out_item expected_q[$];
    t_row      plan[$];

    int idle_pct;
    int hold_requests;
    int cycle_count;
    int n_errors;
    int n_results;
    int n_sent;
    int n_settings;
    int n_ticks;
    int n_wraps;
    int n_end_stops;
    int n_saturations;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one command to the transport copy and return the result
    // transaction the block should produce for it.
    function automatic t_out_item advance_transport(input t_in_item item);
        logic [TIME_BITS:0]   sum;
        logic [TIME_BITS-1:0] span;
        t_out_item            res;
        res = '0;
        case (item.command)
            CMD_PLAY:  trk_playing = 1'b1;
            CMD_PAUSE: trk_playing = 1'b0;
            CMD_STOP: begin
                trk_playing  = 1'b0;
                trk_position = '0;
            end
            CMD_SEEK: begin
                // A duration of zero means the length is unknown, so the
                // target is taken as it is.
                if (cfg_duration != 0 && item.seek_position > cfg_duration)
                    trk_position = cfg_duration;
                else
                    trk_position = item.seek_position;
            end
            CMD_TICK: begin
                n_ticks++;
                if (trk_playing) begin
                    // The sum is one bit wider so that a carry shows an overflow.
                    sum = trk_position + item.tick_delta;
                    if (sum[TIME_BITS]) begin
                        sum = {1'b0, TIME_MAX};
                        res.saturated = 1'b1;
                        n_saturations++;
                    end
                    if (cfg_loop_on) begin
                        // The loop only wraps when its range is valid, and it
                        // never clamps at the duration.
                        if (sum[TIME_BITS-1:0] >= cfg_loop_end
                                && cfg_loop_end > cfg_loop_start) begin
                            span = cfg_loop_end - cfg_loop_start;
                            sum  = {1'b0, cfg_loop_start
                                    + (sum[TIME_BITS-1:0] - cfg_loop_end) % span};
                            n_wraps++;
                        end
                    end else if (sum[TIME_BITS-1:0] >= cfg_duration) begin
                        sum             = {1'b0, cfg_duration};
                        trk_playing     = 1'b0;
                        res.end_reached = 1'b1;
                        n_end_stops++;
                    end
                    trk_position = sum[TIME_BITS-1:0];
                end
            end
            default: ;
        endcase
        res.position_now   = trk_position;
        res.transport_mode = trk_playing ? MODE_PLAYING
                           : (trk_position != 0 ? MODE_PAUSED : MODE_STOPPED);
        res.at_loop_end    = cfg_loop_on && trk_position >= cfg_loop_end;
        return res;
    endfunction

    function automatic void add_cmd(input logic [2:0] cmd, input logic [TIME_BITS-1:0] seek,
                                    input logic [DELTA_BITS-1:0] delta);
        t_row row;
        row = '{kind: ROW_CMD, item: '0, want: '0, idx: REG_LOOP_ENABLE, value: '0};
        row.kind               = ROW_CMD;
        row.item.command       = cmd;
        row.item.seek_position = seek;
        row.item.tick_delta    = delta;
        plan.push_back(row);
    endfunction

    function automatic void add_typed(input logic [2:0] cmd, input logic [TIME_BITS-1:0] seek,
                                      input logic [DELTA_BITS-1:0] delta,
                                      input logic [TIME_BITS-1:0] pos, input t_mode mode,
                                      input logic at_loop, input logic ended, input logic sat);
        t_row row;
        row = '{kind: ROW_CMD_TYPED, item: '0, want: '0, idx: REG_LOOP_ENABLE, value: '0};
        row.kind                = ROW_CMD_TYPED;
        row.item.command        = cmd;
        row.item.seek_position  = seek;
        row.item.tick_delta     = delta;
        row.want.position_now   = pos;
        row.want.transport_mode = mode;
        row.want.at_loop_end    = at_loop;
        row.want.end_reached    = ended;
        row.want.saturated      = sat;
        plan.push_back(row);
    endfunction

    function automatic void add_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] value);
        t_row row;
        row = '{kind: ROW_REG, item: '0, want: '0, idx: REG_LOOP_ENABLE, value: '0};
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = value;
        plan.push_back(row);
    endfunction

    // Offer one command transaction. It may idle first, then it holds valid
    // and the payload until the block accepts them. The expectation is
    // recorded at the edge that accepts the command.
    task automatic send_cmd(input t_in_item item, input bit typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        predicted = advance_transport(item);
        expected_q.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    // Stop offering and wait until every result is back. After that the
    // block has nothing left in flight, and its registers may be changed.
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            REG_LOOP_ENABLE:    cfg_loop_on    = value[0];
            REG_LOOP_START:     cfg_loop_start = value;
            REG_LOOP_END:       cfg_loop_end   = value;
            REG_TRACK_DURATION: cfg_duration   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Ticks and play dominate, so the transport spends most of its time
    // playing, where wraps, clamps and saturation can occur.
    function automatic logic [2:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 46)      return CMD_TICK;
        else if (r < 63) return CMD_PLAY;
        else if (r < 78) return CMD_SEEK;
        else if (r < 86) return CMD_PAUSE;
        else if (r < 93) return CMD_STOP;
        else if (r < 95) return CMD_SPARE_5;
        else if (r < 97) return CMD_SPARE_6;
        else             return CMD_SPARE_7;
    endfunction

    // Seek targets cluster around the loop edges, the duration and the top
    // of the range, where the interesting comparisons happen.
    function automatic logic [TIME_BITS-1:0] pick_target();
        logic [TIME_BITS-1:0] jitter;
        jitter = $urandom_range(32'h1FFFF);
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return cfg_loop_end + jitter - 32'h10000;
            2:       return cfg_duration + jitter - 32'h10000;
            3:       return TIME_MAX - jitter;
            4:       return cfg_loop_start + jitter;
            default: return jitter;
        endcase
    endfunction

    function automatic logic [DELTA_BITS-1:0] pick_delta();
        case ($urandom_range(3))
            0:       return DELTA_BITS'($urandom());
            1:       return DELTA_BITS'($urandom_range(32'hFFFF));
            2:       return '1;
            default: return DELTA_BITS'($urandom_range(32'h3FFFF));
        endcase
    endfunction

    // Program all four registers, then run a burst of random commands. If
    // steady is set, both sides stop idling for the whole burst.
    task automatic run_phase(input bit loop_on, input logic [TIME_BITS-1:0] lp_start,
                             input logic [TIME_BITS-1:0] lp_end,
                             input logic [TIME_BITS-1:0] duration, input bit steady);
        t_in_item item;
        wait_quiet();
        write_reg(REG_LOOP_ENABLE, CFG_BITS'(loop_on));
        write_reg(REG_LOOP_START, lp_start);
        write_reg(REG_LOOP_END, lp_end);
        write_reg(REG_TRACK_DURATION, duration);
        n_settings++;
        idle_pct = steady ? 0 : IDLE_PCT;
        repeat (PHASE_ITEMS) begin
            item.command       = pick_command();
            item.seek_position = pick_target();
            item.tick_delta    = pick_delta();
            if (n_sent == HOLD_AT_ITEM)
                hold_requests++;
            send_cmd(item, 1'b0, '0);
        end
        idle_pct = IDLE_PCT;
    endtask

    // Result side: ready idles at random. When the stimulus asks, it also
    // holds off for a long stretch, so the block backs up and stalls its
    // input.
    initial begin : result_sink
        int holds_done;
        holds_done = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_done < hold_requests) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    function automatic void check_field(input string name, input logic [TIME_BITS-1:0] want,
                                        input logic [TIME_BITS-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            n_errors++;
        end
    endfunction

    // Compare every result transaction with the oldest expectation.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected (position %h)",
                       out_data.position_now);
                n_errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("position_now", want.position_now, out_data.position_now);
                check_field("transport_mode", want.transport_mode, out_data.transport_mode);
                check_field("at_loop_end", want.at_loop_end, out_data.at_loop_end);
                check_field("end_reached", want.end_reached, out_data.end_reached);
                check_field("saturated", want.saturated, out_data.saturated);
                n_results++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TIME_BITS-1:0] rnd_start;
        logic [TIME_BITS-1:0] rnd_end;
        logic [TIME_BITS-1:0] rnd_duration;

        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_LOOP_ENABLE;
        cfg_data      = '0;
        rst_n         = 1'b0;
        idle_pct      = IDLE_PCT;
        hold_requests = 0;
        cycle_count   = 0;
        n_errors      = 0;
        n_results     = 0;
        n_sent        = 0;
        n_settings    = 1;
        n_ticks       = 0;
        n_wraps       = 0;
        n_end_stops   = 0;
        n_saturations = 0;

        // After reset the transport is stopped at zero. The registers read
        // loop off, start zero, end one second and unknown duration.
        trk_playing    = 1'b0;
        trk_position   = '0;
        cfg_loop_on    = 1'b0;
        cfg_loop_start = '0;
        cfg_loop_end   = TIME_ONE;
        cfg_duration   = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, first under the reset register values. A pause or
        // a tick while stopped changes nothing.
        add_typed(CMD_PAUSE, '0, '0, '0, MODE_STOPPED, 0, 0, 0);
        add_typed(CMD_TICK, '0, '1, '0, MODE_STOPPED, 0, 0, 0);
        // With the duration unknown, a seek to the top of the range is taken
        // as it is.
        add_typed(CMD_SEEK, TIME_MAX, '0, TIME_MAX, MODE_PAUSED, 0, 0, 0);
        add_typed(CMD_PLAY, '0, '0, TIME_MAX, MODE_PLAYING, 0, 0, 0);
        add_typed(CMD_PLAY, '0, '0, TIME_MAX, MODE_PLAYING, 0, 0, 0);
        // The sum overflows and saturates. Because the duration is zero, the
        // clamp then stops playback at zero.
        add_typed(CMD_TICK, '0, '1, '0, MODE_STOPPED, 0, 1, 1);
        add_typed(CMD_SPARE_5, TIME_MAX, '1, '0, MODE_STOPPED, 0, 0, 0);
        add_typed(CMD_SPARE_6, TIME_MAX, '1, '0, MODE_STOPPED, 0, 0, 0);
        add_typed(CMD_SPARE_7, TIME_MAX, '1, '0, MODE_STOPPED, 0, 0, 0);
        add_typed(CMD_SEEK, 32'h0002_8000, '0, 32'h0002_8000, MODE_PAUSED, 0, 0, 0);
        add_typed(CMD_PLAY, '0, '0, 32'h0002_8000, MODE_PLAYING, 0, 0, 0);
        // With loop off and zero duration, even a zero-length tick ends the
        // track.
        add_typed(CMD_TICK, '0, '0, '0, MODE_STOPPED, 0, 1, 0);
        add_typed(CMD_SEEK, 32'h1234_5678, '0, 32'h1234_5678, MODE_PAUSED, 0, 0, 0);
        add_typed(CMD_STOP, '0, '0, '0, MODE_STOPPED, 0, 0, 0);

        // Loop from one to three seconds, in a five-second track.
        add_reg(REG_LOOP_ENABLE, 1);
        add_reg(REG_LOOP_START, 32'h0001_0000);
        add_reg(REG_LOOP_END, 32'h0003_0000);
        add_reg(REG_TRACK_DURATION, 32'h0005_0000);
        add_typed(CMD_SEEK, 32'h0002_F000, '0, 32'h0002_F000, MODE_PAUSED, 0, 0, 0);
        add_typed(CMD_PLAY, '0, '0, 32'h0002_F000, MODE_PLAYING, 0, 0, 0);
        add_typed(CMD_TICK, '0, 24'h00_3000, 32'h0001_2000, MODE_PLAYING, 0, 0, 0);
        add_cmd(CMD_TICK, '0, '1);
        // The seek clamps to the duration, which lies past the loop end.
        add_typed(CMD_SEEK, TIME_MAX, '0, 32'h0005_0000, MODE_PLAYING, 1, 0, 0);
        add_cmd(CMD_TICK, '0, '1);

        // Empty loop range and unknown duration: no wrap and no clamp, so the
        // position saturates and keeps playing.
        add_reg(REG_LOOP_END, 32'h0001_0000);
        add_reg(REG_TRACK_DURATION, '0);
        add_typed(CMD_SEEK, 32'hFFFF_FF00, '0, 32'hFFFF_FF00, MODE_PLAYING, 1, 0, 0);
        add_typed(CMD_TICK, '0, '1, TIME_MAX, MODE_PLAYING, 1, 0, 1);
        add_typed(CMD_STOP, '0, '0, '0, MODE_STOPPED, 0, 0, 0);

        // Loop off, two-second track: play up to the end.
        add_reg(REG_LOOP_ENABLE, 0);
        add_reg(REG_TRACK_DURATION, 32'h0002_0000);
        add_typed(CMD_PLAY, '0, '0, '0, MODE_PLAYING, 0, 0, 0);
        add_cmd(CMD_TICK, '0, 24'h01_FFFF);
        add_typed(CMD_TICK, '0, 24'h00_0001, 32'h0002_0000, MODE_PAUSED, 0, 1, 0);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                wait_quiet();
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_cmd(plan[i].item, plan[i].kind == ROW_CMD_TYPED, plan[i].want);
            end
        end
        n_settings += 3;

        // The random phases start at the extremes: a full-range loop, one-step
        // loops at both ends of the range, an inverted range, and durations
        // of zero and of the maximum. Two randomly drawn settings follow.
        run_phase(1'b0, '0, TIME_ONE, TIME_MAX, 1'b0);
        run_phase(1'b1, '0, TIME_MAX, TIME_MAX, 1'b0);
        run_phase(1'b1, '0, 32'h0000_0001, 32'h0004_0000, 1'b1);
        run_phase(1'b1, TIME_MAX - 1, TIME_MAX, '0, 1'b0);
        run_phase(1'b1, 32'h0000_8000, 32'h0005_0000, 32'h0004_0000, 1'b0);
        run_phase(1'b1, 32'h0005_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        run_phase(1'b0, '0, TIME_ONE, '0, 1'b0);
        run_phase(1'b0, '0, TIME_ONE, 32'h0008_0000, 1'b0);
        rnd_start    = $urandom_range(32'h3F_FFFF);
        rnd_end      = rnd_start + $urandom_range(32'h3F_FFFF);
        rnd_duration = $urandom_range(32'h7F_FFFF);
        run_phase(1'($urandom_range(1)), rnd_start, rnd_end, rnd_duration, 1'b0);
        rnd_start    = $urandom();
        rnd_end      = $urandom();
        rnd_duration = $urandom();
        run_phase(1'($urandom_range(1)), rnd_start, rnd_end, rnd_duration, 1'b0);

        wait_quiet();
        $display("Checked %0d results from %0d commands under %0d register settings.",
                 n_results, n_sent, n_settings);
        $display("Ticks %0d: %0d loop wraps, %0d end-of-track stops, %0d saturations.",
                 n_ticks, n_wraps, n_end_stops, n_saturations);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/ptp_pkg.sv
src/ptp_cfg.sv
src/ptp_mod.sv
src/playback_transport_position_top.sv
src/ptp_checker.sv
tb/tb_playback_transport_position_top.sv
